// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DNS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define DNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/dns_pkg.sv =====
`timescale 1ns / 1ps
package dns_pkg;

  localparam int MAXV    = 20;
  localparam int VCW     = $clog2(MAXV + 1);
  localparam int IDW     = $clog2(MAXV);
  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 5;
  localparam int Q_DEPTH = 4;
  localparam int QPW     = $clog2(Q_DEPTH);

  localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONN  = 2'd2;

  typedef logic [MAXV-1:0] row_t;

  typedef struct packed {
    row_t           row;
    logic [IDW-1:0] idx;
    logic           keep;
    logic           last;
    logic [VCW-1:0] n;
    logic           ovf;
  } dns_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dns_qstat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] set_size;
    logic              exists;
    logic              rows_overflowed;
  } dns_result_t;

  function automatic logic [VCW-1:0] popcount(input row_t s);
    logic [VCW-1:0] acc;
    acc = '0;
    for (int i = 0; i < MAXV; i++) begin
      acc = acc + VCW'(s[i]);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/domination_number_search.sv =====
`timescale 1ns / 1ps
// Smallest dominating set search over a graph loaded one adjacency row per request.
// Input queue: drive in_row_bits / in_last_row and raise push; a request is taken
//   at a clock edge with push high and full low. Rows are taken one per cycle
//   while the four-entry row queue has room.
// The request with in_last_row set closes the graph and starts the search.
// Configuration: cfg_wr_en writes cfg_wr_data into the kind register
//   (0 plain, 1 total, 2 connected); write it only while the block is idle.
// Result queue: while empty is low the result sits on out_set_size, out_exists
//   and out_rows_overflowed; pop with empty low takes it.
// Search: the searcher walks every nonempty subset of the n vertices in turn, one
//   per cycle. In connected mode each candidate that dominates and beats the best
//   so far first runs a reachability walk over its own vertices, which holds the
//   scan until the walk ends.
// Rows past twenty are dropped and flagged in the result.
// When the result is not popped the searcher holds in its final step, and the
//   row queue fills, after which full stays high.
// Reset (rst_n low, synchronous) empties both queues, clears the row count,
//   the overflow flag and the kind register.
`include "assert_macros.svh"
module domination_number_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [dns_pkg::MAXV-1:0]   in_row_bits,
  input  logic                       in_last_row,
  output logic                       empty,
  input  logic                       pop,
  output logic [dns_pkg::SIZE_W-1:0] out_set_size,
  output logic                       out_exists,
  output logic                       out_rows_overflowed,
  input  logic                       cfg_wr_en,
  input  logic [dns_pkg::KIND_W-1:0] cfg_wr_data
);

  logic [dns_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                       accept;
  logic                       q_pop;
  logic                       out_valid;
  dns_pkg::dns_entry_t        f_entry, q_entry;
  dns_pkg::dns_qstat_t        q_stat;
  dns_pkg::dns_result_t       result;

  assign accept   = push & ~q_stat.full;
  assign full     = q_stat.full;
  assign kind_nxt = cfg_wr_en ? cfg_wr_data : kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= dns_pkg::KIND_PLAIN;
    end else begin
      kind_r <= kind_nxt;
    end
  end

  dns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .row_i    (in_row_bits),
    .last_i   (in_last_row),
    .entry_o  (f_entry)
  );

  dns_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (accept),
    .data_i (f_entry),
    .pop_i  (q_pop),
    .data_o (q_entry),
    .stat_o (q_stat)
  );

  dns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .kind_i      (kind_r),
    .q_data_i    (q_entry),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_o       (result)
  );

  assign empty               = ~out_valid;
  assign out_set_size        = result.set_size;
  assign out_exists          = result.exists;
  assign out_rows_overflowed = result.rows_overflowed;

  `DNS_ASSERT_NOW(a_full_not_empty, clk, rst_n, q_stat.full, !q_stat.empty)
  `DNS_ASSERT_NOW(a_found_size, clk, rst_n, !empty && out_exists,
    out_set_size != '0 && out_set_size <= dns_pkg::SIZE_W'(dns_pkg::MAXV))
  `DNS_ASSERT_NOW(a_ovf_missing, clk, rst_n, !empty && out_rows_overflowed && !out_exists,
    out_set_size == '0 || out_set_size == dns_pkg::SIZE_W'(dns_pkg::MAXV))
  `DNS_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(result))

endmodule

// ===== hw/rtl/dns_front.sv =====
`timescale 1ns / 1ps
module dns_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept_i,
  input  dns_pkg::row_t       row_i,
  input  logic                last_i,
  output dns_pkg::dns_entry_t entry_o
);

  logic [dns_pkg::VCW-1:0] count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    keep;

  assign keep = (count_r < dns_pkg::VCW'(dns_pkg::MAXV));

  always_comb begin
    entry_o.row  = row_i;
    entry_o.idx  = count_r[dns_pkg::IDW-1:0];
    entry_o.keep = keep;
    entry_o.last = last_i;
    entry_o.n    = keep ? count_r + dns_pkg::VCW'(1) : count_r;
    entry_o.ovf  = ovf_r | ~keep;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept_i) begin
      if (last_i) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = entry_o.n;
        ovf_nxt   = entry_o.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== hw/rtl/dns_fifo.sv =====
`timescale 1ns / 1ps
module dns_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  dns_pkg::dns_entry_t data_i,
  input  logic                pop_i,
  output dns_pkg::dns_entry_t data_o,
  output dns_pkg::dns_qstat_t stat_o
);

  dns_pkg::dns_entry_t     mem_r [dns_pkg::Q_DEPTH];
  logic [dns_pkg::QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dns_pkg::QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dns_pkg::QPW:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign stat_o.full  = (cnt_r == (dns_pkg::QPW+1)'(dns_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_r == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign data_o       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + dns_pkg::QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + dns_pkg::QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (dns_pkg::QPW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (dns_pkg::QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dns_back.sv =====
`timescale 1ns / 1ps
module dns_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dns_pkg::KIND_W-1:0]  kind_i,
  input  dns_pkg::dns_entry_t         q_data_i,
  input  dns_pkg::dns_qstat_t         q_stat_i,
  output logic                        q_pop_o,
  input  logic                        out_pop_i,
  output logic                        out_valid_o,
  output dns_pkg::dns_result_t        out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_BFS  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam dns_pkg::row_t ONE  = dns_pkg::row_t'(1);
  localparam dns_pkg::row_t ONES = '1;

  logic [1:0]                state_r, state_nxt;
  dns_pkg::row_t             rows_r [dns_pkg::MAXV];
  logic [dns_pkg::VCW-1:0]   n_r, n_nxt;
  logic                      ovf_r, ovf_nxt;
  dns_pkg::row_t             full_r, full_nxt;
  dns_pkg::row_t             subset_r, subset_nxt;
  dns_pkg::row_t             seen_r, seen_nxt;
  dns_pkg::row_t             front_r, front_nxt;
  logic [dns_pkg::VCW-1:0]   best_r, best_nxt;
  logic                      found_r, found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dns_pkg::dns_result_t      out_r, out_nxt;

  dns_pkg::row_t             cov, reach, next_set, selfmask;
  logic [dns_pkg::VCW-1:0]   pc;
  logic                      dominated, better, last_subset, slot_free;

  always_comb begin
    cov   = '0;
    reach = '0;
    for (int v = 0; v < dns_pkg::MAXV; v++) begin
      selfmask    = full_r;
      selfmask[v] = 1'b0;
      if (subset_r[v]) begin
        cov = cov | (rows_r[v] & selfmask);
      end
      if (front_r[v]) begin
        reach = reach | rows_r[v];
      end
    end
    next_set = reach & subset_r & ~seen_r;
  end

  assign pc          = dns_pkg::popcount(subset_r);
  assign dominated   = (kind_i == dns_pkg::KIND_TOTAL) ? (cov == full_r)
                                                       : ((cov | subset_r) == full_r);
  assign better      = ~found_r | (pc < best_r);
  assign last_subset = (subset_r == full_r);
  assign slot_free   = ~out_valid_r | out_pop_i;
  assign q_pop_o     = (state_r == ST_IDLE) & ~q_stat_i.empty;
  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    full_nxt      = full_r;
    subset_nxt    = subset_r;
    seen_nxt      = seen_r;
    front_nxt     = front_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r & ~out_pop_i;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop_o && q_data_i.last) begin
          n_nxt      = q_data_i.n;
          ovf_nxt    = q_data_i.ovf;
          full_nxt   = ~(ONES << q_data_i.n);
          subset_nxt = ONE;
          best_nxt   = '0;
          if (q_data_i.n == '0) begin
            found_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (dominated && better && kind_i == dns_pkg::KIND_CONN) begin
          seen_nxt  = subset_r & (~subset_r + ONE);
          front_nxt = subset_r & (~subset_r + ONE);
          state_nxt = ST_BFS;
        end else begin
          if (dominated && better) begin
            best_nxt  = pc;
            found_nxt = 1'b1;
          end
          if (last_subset) begin
            state_nxt = ST_DONE;
          end else begin
            subset_nxt = subset_r + ONE;
          end
        end
      end
      ST_BFS: begin
        if (next_set == '0) begin
          if (seen_r == subset_r) begin
            best_nxt  = pc;
            found_nxt = 1'b1;
          end
          if (last_subset) begin
            state_nxt = ST_DONE;
          end else begin
            subset_nxt = subset_r + ONE;
            state_nxt  = ST_SCAN;
          end
        end else begin
          seen_nxt  = seen_r | next_set;
          front_nxt = next_set;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_nxt.set_size = dns_pkg::SIZE_W'(best_r);
          end else if (kind_i == dns_pkg::KIND_CONN) begin
            out_nxt.set_size = dns_pkg::SIZE_W'(n_r);
          end else begin
            out_nxt.set_size = '0;
          end
          out_nxt.exists          = found_r;
          out_nxt.rows_overflowed = ovf_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop_o && q_data_i.keep) begin
      rows_r[q_data_i.idx] <= q_data_i.row;
    end
    n_r      <= n_nxt;
    ovf_r    <= ovf_nxt;
    full_r   <= full_nxt;
    subset_r <= subset_nxt;
    seen_r   <= seen_nxt;
    front_r  <= front_nxt;
    best_r   <= best_nxt;
    found_r  <= found_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
